FILE: sv/tcw_pkg.sv
// Package with the shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 32;

  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] LINE_FEED    = 8'd10;
  localparam logic [7:0] CARRIAGE_RET = 8'd13;
  localparam logic [7:0] ATTR_RESET   = 8'd240;
  localparam logic [7:0] COLS_RESET   = 8'd80;
  localparam logic [5:0] ROWS_RESET   = 6'd30;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } tcw_op_t;

  typedef enum logic [1:0] {
    REG_TEXT_ATTRIBUTE = 2'd0,
    REG_COLUMNS_IN_USE = 2'd1,
    REG_ROWS_IN_USE    = 2'd2
  } tcw_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_HOLD
  } tcw_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] color;
  } tcw_cell_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       did_scroll;
  } tcw_result_t;

endpackage

FILE: sv/tcw_if.sv
// Item channel interfaces for the command and response sides of the console writer.
`timescale 1ns / 1ps

interface tcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [7:0] target_col;
  logic [7:0] target_row;

  modport source (output valid, opcode, char_code, target_col, target_row, input ready);
  modport sink (input valid, opcode, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_color;
  logic       did_scroll;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_color, did_scroll,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, cell_char, cell_color, did_scroll,
                output ready);
endinterface

FILE: sv/tcw_store.sv
// Screen cell memory: one write port and one registered read port.
`timescale 1ns / 1ps

module tcw_store #(
  parameter int  DEPTH  = tcw_pkg::DEF_MAX_COLUMNS * tcw_pkg::DEF_MAX_ROWS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  tcw_pkg::tcw_cell_t wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output tcw_pkg::tcw_cell_t rdata
);
  import tcw_pkg::*;

  tcw_cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tcw_sequencer.sv
// Sequencer that runs each operation as reads and writes of the cell memory.
`timescale 1ns / 1ps

module tcw_sequencer #(
  parameter int  MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter int  MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS,
  localparam int ADDR_W      = $clog2(MAX_COLUMNS * MAX_ROWS)
) (
  input  logic               clk,
  input  logic               rst,
  tcw_cmd_if.sink            cmd,
  input  logic [7:0]         text_attribute,
  input  logic [7:0]         columns_in_use,
  input  logic [5:0]         rows_in_use,
  output logic               res_valid,
  input  logic               res_ready,
  output tcw_pkg::tcw_result_t res,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_waddr,
  output tcw_pkg::tcw_cell_t mem_wdata,
  output logic               mem_re,
  output logic [ADDR_W-1:0]  mem_raddr,
  input  tcw_pkg::tcw_cell_t mem_rdata
);
  import tcw_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = ROW_W + CCNT_W;
  localparam int TOT_W  = $clog2(DEPTH + 1);

  tcw_state_t state, state_next;

  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              scrolled, scrolled_next;
  logic              copy_wvalid;
  logic [ADDR_W-1:0] copy_waddr;
  tcw_op_t           item_op;
  logic [7:0]        item_code;
  logic [7:0]        item_col;
  logic [7:0]        item_row;
  logic [7:0]        res_char;
  logic [7:0]        res_color;
  logic [ADDR_W-1:0] fill_last;
  logic [ADDR_W-1:0] scroll_start;

  logic [CCNT_W-1:0] cols_lim, col_last, col_inc;
  logic [RCNT_W-1:0] rows_lim, row_last;
  logic [TOT_W-1:0]  cells;
  logic [COL_W-1:0]  ccol, tcol_c, col_sel;
  logic [ROW_W-1:0]  crow, trow_c, row_sel;
  logic [PROD_W-1:0] row_base;
  logic [ADDR_W-1:0] cell_addr;
  logic              is_nl, wrap, new_line, last_row, exec_scroll;
  logic              accept, fill_done, copy_done;

  always_comb begin
    if (columns_in_use == '0) begin
      cols_lim = CCNT_W'(1);
    end else if (16'(columns_in_use) > 16'(MAX_COLUMNS)) begin
      cols_lim = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols_lim = CCNT_W'(columns_in_use);
    end
    if (rows_in_use == '0) begin
      rows_lim = RCNT_W'(1);
    end else if (16'(rows_in_use) > 16'(MAX_ROWS)) begin
      rows_lim = RCNT_W'(MAX_ROWS);
    end else begin
      rows_lim = RCNT_W'(rows_in_use);
    end
  end

  assign col_last = cols_lim - CCNT_W'(1);
  assign row_last = rows_lim - RCNT_W'(1);
  assign cells    = TOT_W'(cols_lim) * TOT_W'(rows_lim);

  assign ccol   = (16'(cur_col) > 16'(col_last)) ? COL_W'(col_last) : cur_col;
  assign crow   = (16'(cur_row) > 16'(row_last)) ? ROW_W'(row_last) : cur_row;
  assign tcol_c = (16'(item_col) > 16'(col_last)) ? COL_W'(col_last) : COL_W'(item_col);
  assign trow_c = (16'(item_row) > 16'(row_last)) ? ROW_W'(row_last) : ROW_W'(item_row);

  assign row_sel   = (item_op == OP_READ) ? trow_c : crow;
  assign col_sel   = (item_op == OP_READ) ? tcol_c : ccol;
  assign row_base  = PROD_W'(row_sel) * PROD_W'(cols_lim);
  assign cell_addr = ADDR_W'(row_base) + ADDR_W'(col_sel);

  assign is_nl       = (item_code == LINE_FEED) || (item_code == CARRIAGE_RET);
  assign col_inc     = CCNT_W'(ccol) + CCNT_W'(1);
  assign wrap        = (col_inc == cols_lim);
  assign new_line    = is_nl || wrap;
  assign last_row    = (RCNT_W'(crow) == row_last);
  assign exec_scroll = (item_op == OP_PUT) && new_line && last_row;

  assign accept    = cmd.valid && cmd.ready;
  assign fill_done = (ptr == fill_last);
  assign copy_done = (ptr == scroll_start - ADDR_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (ptr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (item_op)
          OP_CLEAR: state_next = ST_FILL;
          OP_READ:  state_next = ST_READ;
          OP_PUT: begin
            if (exec_scroll) begin
              state_next = (rows_lim == RCNT_W'(1)) ? ST_FILL : ST_COPY;
            end else begin
              state_next = res_ready ? ST_IDLE : ST_HOLD;
            end
          end
          default: state_next = res_ready ? ST_IDLE : ST_HOLD;
        endcase
      end
      ST_READ: state_next = res_ready ? ST_IDLE : ST_HOLD;
      ST_COPY: begin
        if (copy_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FILL;
      ST_FILL: begin
        if (fill_done) state_next = res_ready ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    ptr_next      = ptr + ADDR_W'(1);
    scrolled_next = scrolled;
    case (state)
      ST_IDLE: begin
        if (accept) scrolled_next = 1'b0;
      end
      ST_EXEC: begin
        case (item_op)
          OP_PUT: begin
            cur_row_next = crow;
            ptr_next     = '0;
            if (new_line) begin
              cur_col_next = '0;
              if (last_row) begin
                scrolled_next = 1'b1;
              end else begin
                cur_row_next = crow + ROW_W'(1);
              end
            end else begin
              cur_col_next = COL_W'(col_inc);
            end
          end
          OP_MOVE: begin
            cur_col_next = tcol_c;
            cur_row_next = trow_c;
          end
          OP_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            ptr_next     = '0;
          end
          default: ptr_next = ptr;
        endcase
      end
      ST_DRAIN: ptr_next = ptr;
      default: ptr_next = ptr + ADDR_W'(1);
    endcase
  end

  always_comb begin
    cmd.ready = (state == ST_IDLE);
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = '{char_code: SPACE_CODE, color: text_attribute};
    mem_re    = 1'b0;
    mem_raddr = cell_addr;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{char_code: SPACE_CODE, color: ATTR_RESET};
      end
      ST_EXEC: begin
        mem_we    = (item_op == OP_PUT) && !is_nl;
        mem_waddr = cell_addr;
        mem_wdata = '{char_code: item_code, color: text_attribute};
        mem_re    = (item_op == OP_READ);
        res_valid = (item_op == OP_MOVE) || ((item_op == OP_PUT) && !exec_scroll);
      end
      ST_READ: res_valid = 1'b1;
      ST_COPY, ST_DRAIN: begin
        mem_we    = copy_wvalid;
        mem_waddr = copy_waddr;
        mem_wdata = mem_rdata;
        mem_re    = (state == ST_COPY);
        mem_raddr = ptr + ADDR_W'(cols_lim);
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        res_valid = fill_done;
      end
      ST_HOLD: res_valid = 1'b1;
      default: res_valid = 1'b0;
    endcase
  end

  always_comb begin
    res.cursor_col = 7'(cur_col_next);
    res.cursor_row = 5'(cur_row_next);
    res.cell_char  = (state == ST_READ) ? mem_rdata.char_code : res_char;
    res.cell_color = (state == ST_READ) ? mem_rdata.color : res_color;
    res.did_scroll = scrolled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cur_col     <= '0;
      cur_row     <= '0;
      ptr         <= '0;
      scrolled    <= 1'b0;
      copy_wvalid <= 1'b0;
    end else begin
      state       <= state_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      ptr         <= ptr_next;
      scrolled    <= scrolled_next;
      copy_wvalid <= (state == ST_COPY);
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr   <= ptr;
    fill_last    <= ADDR_W'(cells - TOT_W'(1));
    scroll_start <= ADDR_W'(cells - TOT_W'(cols_lim));
    if (accept) begin
      item_op   <= tcw_op_t'(cmd.opcode);
      item_code <= cmd.char_code;
      item_col  <= cmd.target_col;
      item_row  <= cmd.target_row;
      res_char  <= '0;
      res_color <= '0;
    end else if (state == ST_READ) begin
      res_char  <= mem_rdata.char_code;
      res_color <= mem_rdata.color;
    end
  end

endmodule

FILE: sv/tcw_result_reg.sv
// Output register that holds one finished result item until it is taken.
`timescale 1ns / 1ps

module tcw_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  tcw_pkg::tcw_result_t res,
  tcw_rsp_if.source            rsp
);
  import tcw_pkg::*;

  logic        full;
  tcw_result_t data;

  assign res_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (res_valid && res_ready) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data <= res;
    end
  end

  assign rsp.valid      = full;
  assign rsp.cursor_col = data.cursor_col;
  assign rsp.cursor_row = data.cursor_row;
  assign rsp.cell_char  = data.cell_char;
  assign rsp.cell_color = data.cell_color;
  assign rsp.did_scroll = data.did_scroll;

endmodule

FILE: sv/text_console_writer.sv
// Top level of the text console writer: configuration registers and block wiring.
//
//   Channel  Direction  Handshake        Contents
//   cmd      in         valid / ready    opcode, char_code, target_col, target_row
//   rsp      out        valid / ready    cursor_col, cursor_row, cell_char, cell_color,
//                                        did_scroll
//   cfg      in         cfg_we           cfg_index, cfg_data
//
// A character, a line break without scroll or a cursor move is done in ST_EXEC; a cell
// read goes on to ST_READ, set by the registered read port of the cell memory.
// A clear fills every cell in use in ST_FILL; a scrolling line break copies the rows up in
// ST_COPY and ST_DRAIN, then fills the last row in ST_FILL (on a single row, nothing is
// copied), as the single write port of the memory moves one cell a cycle.
// After reset every cell of the memory is written once, during which cmd.ready stays low.
// A result waits in the output register, so the next item is taken while it stalls.
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  tcw_cmd_if.sink    cmd,
  tcw_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tcw_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] text_attribute;
  logic [7:0] columns_in_use;
  logic [5:0] rows_in_use;

  logic              res_valid;
  logic              res_ready;
  tcw_result_t       res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  tcw_cell_t         mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  tcw_cell_t         mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
      columns_in_use <= COLS_RESET;
      rows_in_use    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_ATTRIBUTE: text_attribute <= cfg_data;
        REG_COLUMNS_IN_USE: columns_in_use <= cfg_data;
        REG_ROWS_IN_USE:    rows_in_use    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  tcw_sequencer #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_sequencer (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .text_attribute (text_attribute),
    .columns_in_use (columns_in_use),
    .rows_in_use    (rows_in_use),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  tcw_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

endmodule

FILE: sv/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [6:0] rsp_cursor_col,
  input logic [4:0] rsp_cursor_row,
  input logic [7:0] rsp_cell_char,
  input logic [7:0] rsp_cell_color,
  input logic       rsp_did_scroll
);

  // The block is busy straight after reset while the memory is cleared.
  a_busy_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !cmd_ready)
    else $error("item accepted during the clearing pass after reset");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("a second item was taken before the first one finished");

  // A stalled result item holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_cursor_col, rsp_cursor_row, rsp_cell_char, rsp_cell_color,
               rsp_did_scroll}))
    else $error("stalled result item changed or vanished");

  // A scroll always leaves the cursor at the start of a line and reports no cell data.
  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_did_scroll |-> rsp_cursor_col == 7'd0 &&
      rsp_cell_char == 8'd0 && rsp_cell_color == 8'd0)
    else $error("scroll result with cursor off column zero or cell data set");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_cursor_col (rsp.cursor_col),
  .rsp_cursor_row (rsp.cursor_row),
  .rsp_cell_char  (rsp.cell_char),
  .rsp_cell_color (rsp.cell_color),
  .rsp_did_scroll (rsp.did_scroll)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the text console writer, with its own console model.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int MAXC = DEF_MAX_COLUMNS;
  localparam int MAXR = DEF_MAX_ROWS;
  localparam int CELL_COUNT = MAXC * MAXR;
  localparam int ITEM_TOTAL = 1450;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit          is_write;
    logic [1:0]  idx;
    logic [7:0]  wdata;
    tcw_op_t     op;
    logic [7:0]  code;
    logic [7:0]  tcol;
    logic [7:0]  trow;
    bit          known;
    tcw_result_t want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       reply_ready = 1'b0;
  bit         steady = 1'b0;
  int         faults = 0;
  int         sent = 0;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();

  assign rsp_ch.ready = reply_ready;

  text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Console state as the block should hold it.
  logic [7:0]  char_mem  [0:CELL_COUNT-1];
  logic [7:0]  color_mem [0:CELL_COUNT-1];
  int unsigned cur_c;
  int unsigned cur_r;
  logic [7:0]  attr_reg;
  logic [7:0]  cols_reg;
  logic [5:0]  rows_reg;

  tcw_result_t pending_reports[$];
  plan_row_t   plan[$];

  function automatic int unsigned size_limit(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned clamp_to_last(int unsigned v, int unsigned last);
    return (v > last) ? last : v;
  endfunction

  function automatic void blank_cells(int unsigned start, int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (start + i < CELL_COUNT) begin
        char_mem[start + i]  = SPACE_CODE;
        color_mem[start + i] = attr_reg;
      end
    end
  endfunction

  function automatic bit line_break(int unsigned cols, int unsigned rows);
    cur_c = 0;
    cur_r++;
    if (cur_r < rows) return 1'b0;
    for (int unsigned i = 0; i < cols * (rows - 1); i++) begin
      char_mem[i]  = char_mem[i + cols];
      color_mem[i] = color_mem[i + cols];
    end
    blank_cells(cols * (rows - 1), cols);
    cur_r = rows - 1;
    return 1'b1;
  endfunction

  function automatic tcw_result_t console_apply(tcw_op_t op, logic [7:0] code,
                                                logic [7:0] tcol, logic [7:0] trow);
    int unsigned cols;
    int unsigned rows;
    int unsigned a;
    tcw_result_t res;
    cols = size_limit(cols_reg, MAXC);
    rows = size_limit(rows_reg, MAXR);
    res = '0;
    case (op)
      OP_PUT: begin
        cur_c = clamp_to_last(cur_c, cols - 1);
        cur_r = clamp_to_last(cur_r, rows - 1);
        if (code == LINE_FEED || code == CARRIAGE_RET) begin
          res.did_scroll = line_break(cols, rows);
        end else begin
          a = cur_r * cols + cur_c;
          char_mem[a]  = code;
          color_mem[a] = attr_reg;
          cur_c++;
          if (cur_c >= cols) res.did_scroll = line_break(cols, rows);
        end
      end
      OP_MOVE: begin
        cur_c = clamp_to_last(tcol, cols - 1);
        cur_r = clamp_to_last(trow, rows - 1);
      end
      OP_CLEAR: begin
        blank_cells(0, cols * rows);
        cur_c = 0;
        cur_r = 0;
      end
      default: begin
        a = clamp_to_last(trow, rows - 1) * cols + clamp_to_last(tcol, cols - 1);
        res.cell_char  = char_mem[a];
        res.cell_color = color_mem[a];
      end
    endcase
    res.cursor_col = cur_c[6:0];
    res.cursor_row = cur_r[4:0];
    return res;
  endfunction

  function automatic void plan_reg(logic [1:0] idx, logic [7:0] data);
    plan_row_t row;
    row = '{op: OP_PUT, default: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.wdata = data;
    plan.push_back(row);
  endfunction

  function automatic void plan_cmd(tcw_op_t op, logic [7:0] code, logic [7:0] tcol,
                                   logic [7:0] trow, bit known, int cc, int cr, int ch,
                                   int co, int sc);
    plan_row_t row;
    row = '{op: OP_PUT, default: '0};
    row.op = op;
    row.code = code;
    row.tcol = tcol;
    row.trow = trow;
    row.known = known;
    row.want.cursor_col = cc[6:0];
    row.want.cursor_row = cr[4:0];
    row.want.cell_char  = ch[7:0];
    row.want.cell_color = co[7:0];
    row.want.did_scroll = sc[0];
    plan.push_back(row);
  endfunction

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_TEXT_ATTRIBUTE: attr_reg = data;
      REG_COLUMNS_IN_USE: cols_reg = data;
      REG_ROWS_IN_USE:    rows_reg = data[5:0];
      default: ;
    endcase
  endtask

  task automatic send_cmd(tcw_op_t op, logic [7:0] code, logic [7:0] tcol,
                          logic [7:0] trow, bit known, tcw_result_t want);
    tcw_result_t model_res;
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < 18) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.char_code <= code;
    cmd_ch.target_col <= tcol;
    cmd_ch.target_row <= trow;
    do @(posedge clk); while (!cmd_ch.ready);
    model_res = console_apply(op, code, tcol, trow);
    pending_reports.push_back(known ? want : model_res);
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reply_ready <= 1'b0;
    end else begin
      reply_ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin : check_reply
    tcw_result_t want;
    tcw_result_t got;
    if (!rst && rsp_ch.valid && reply_ready) begin
      got = {rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.cell_char, rsp_ch.cell_color,
             rsp_ch.did_scroll};
      if (pending_reports.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("Unexpected item: col %0d row %0d char %0d color %0d scroll %0d",
                   got.cursor_col, got.cursor_row, got.cell_char, got.cell_color,
                   got.did_scroll);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
            got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
            got.did_scroll !== want.did_scroll) begin
          faults++;
          if (faults <= 10) begin
            $display("Mismatch at %0t: expected col %0d row %0d char %0d color %0d scroll %0d",
                     $time, want.cursor_col, want.cursor_row, want.cell_char,
                     want.cell_color, want.did_scroll);
            $display("  actual col %0d row %0d char %0d color %0d scroll %0d",
                     got.cursor_col, got.cursor_row, got.cell_char, got.cell_color,
                     got.did_scroll);
          end
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit          prev_write;
    int          phase;
    int          burst;
    int unsigned cols;
    int unsigned rows;
    int unsigned pick;
    logic [7:0]  col_val;
    logic [7:0]  row_val;
    logic [7:0]  code;
    logic [7:0]  tcol;
    logic [7:0]  trow;
    tcw_op_t     op;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.opcode <= '0;
    cmd_ch.char_code <= '0;
    cmd_ch.target_col <= '0;
    cmd_ch.target_row <= '0;

    for (int i = 0; i < CELL_COUNT; i++) begin
      char_mem[i]  = SPACE_CODE;
      color_mem[i] = ATTR_RESET;
    end
    cur_c = 0;
    cur_r = 0;
    attr_reg = ATTR_RESET;
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;

    plan_cmd(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  0,  32,    240, 0);
    plan_cmd(OP_READ,  8'h00, 8'd255, 8'd255, 1, 0,  0,  32,    240, 0);
    plan_cmd(OP_PUT,   8'h41, 8'd0,   8'd0,   1, 1,  0,  0,     0,   0);
    plan_cmd(OP_PUT,   8'h00, 8'd0,   8'd0,   1, 2,  0,  0,     0,   0);
    plan_cmd(OP_PUT,   8'hFF, 8'd0,   8'd0,   1, 3,  0,  0,     0,   0);
    plan_cmd(OP_PUT,   LINE_FEED,    8'd0, 8'd0, 1, 0, 1, 0,    0,   0);
    plan_cmd(OP_PUT,   CARRIAGE_RET, 8'd0, 8'd0, 1, 0, 2, 0,    0,   0);
    plan_cmd(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  2,  8'h41, 240, 0);
    plan_cmd(OP_READ,  8'h00, 8'd2,   8'd0,   1, 0,  2,  8'hFF, 240, 0);
    plan_cmd(OP_MOVE,  8'h00, 8'd255, 8'd255, 1, 79, 29, 0,     0,   0);
    plan_cmd(OP_PUT,   8'h5A, 8'd0,   8'd0,   1, 0,  29, 0,     0,   1);
    plan_cmd(OP_READ,  8'h00, 8'd79,  8'd28,  1, 0,  29, 8'h5A, 240, 0);
    plan_cmd(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  29, 32,    240, 0);
    plan_cmd(OP_MOVE,  8'h00, 8'd5,   8'd255, 1, 5,  29, 0,     0,   0);
    plan_cmd(OP_PUT,   LINE_FEED, 8'd0, 8'd0, 1, 0,  29, 0,     0,   1);
    plan_cmd(OP_READ,  8'h00, 8'd79,  8'd27,  0, 0,  0,  0,     0,   0);
    plan_cmd(OP_CLEAR, 8'h00, 8'd0,   8'd0,   1, 0,  0,  0,     0,   0);
    plan_cmd(OP_READ,  8'h00, 8'd10,  8'd10,  1, 0,  0,  32,    240, 0);
    // A single row of four columns: wrapping clears the only row.
    plan_reg(REG_TEXT_ATTRIBUTE, 8'h1F);
    plan_reg(REG_COLUMNS_IN_USE, 8'd4);
    plan_reg(REG_ROWS_IN_USE, 8'd1);
    plan_cmd(OP_PUT,   8'h61, 8'd0,   8'd0,   1, 1,  0,  0,     0,   0);
    plan_cmd(OP_MOVE,  8'h00, 8'd255, 8'd255, 1, 3,  0,  0,     0,   0);
    plan_cmd(OP_PUT,   8'h64, 8'd0,   8'd0,   1, 0,  0,  0,     0,   1);
    plan_cmd(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  0,  32,    8'h1F, 0);
    // Zero sizes count as one; the row register keeps only six bits.
    plan_reg(REG_COLUMNS_IN_USE, 8'd0);
    plan_reg(REG_ROWS_IN_USE, 8'd64);
    plan_cmd(OP_PUT,   8'h71, 8'd0,   8'd0,   1, 0,  0,  0,     0,   1);
    // The cursor is left beyond a shrunken screen.
    plan_reg(REG_COLUMNS_IN_USE, COLS_RESET);
    plan_reg(REG_ROWS_IN_USE, {2'b00, ROWS_RESET});
    plan_cmd(OP_MOVE,  8'h00, 8'd70,  8'd20,  1, 70, 20, 0,     0,   0);
    plan_reg(REG_COLUMNS_IN_USE, 8'd10);
    plan_reg(REG_ROWS_IN_USE, 8'd5);
    plan_reg(REG_UNUSED, 8'hA5);
    plan_cmd(OP_READ,  8'h00, 8'd3,   8'd2,   0, 0,  0,  0,     0,   0);
    plan_cmd(OP_PUT,   8'h78, 8'd0,   8'd0,   1, 0,  4,  0,     0,   1);
    plan_reg(REG_COLUMNS_IN_USE, 8'd255);
    plan_reg(REG_ROWS_IN_USE, 8'hFF);
    plan_cmd(OP_MOVE,  8'h00, 8'd255, 8'd255, 1, 127, 31, 0,    0,   0);
    plan_cmd(OP_READ,  8'h00, 8'd127, 8'd31,  0, 0,  0,  0,     0,   0);
    plan_cmd(OP_CLEAR, 8'h00, 8'd0,   8'd0,   1, 0,  0,  0,     0,   0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    prev_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!prev_write) settle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_cmd(plan[i].op, plan[i].code, plan[i].tcol, plan[i].trow, plan[i].known,
                 plan[i].want);
      end
      prev_write = plan[i].is_write;
    end

    phase = 0;
    while (sent < ITEM_TOTAL) begin
      settle();
      case (phase)
        2:  begin col_val = 8'd255; row_val = 8'd63; end
        7:  begin col_val = 8'd128; row_val = 8'd32; end
        10: begin col_val = 8'd0;   row_val = 8'd0;  end
        11: begin col_val = 8'd200; row_val = 8'hC3; end
        12: begin col_val = 8'd1;   row_val = 8'd32; end
        default: begin
          col_val = 8'($urandom_range(16, 1));
          row_val = 8'($urandom_range(8, 1));
        end
      endcase
      write_reg(REG_TEXT_ATTRIBUTE, 8'($urandom_range(255)));
      write_reg(REG_COLUMNS_IN_USE, col_val);
      write_reg(REG_ROWS_IN_USE, row_val);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 8'($urandom_range(255)));
      cols = size_limit(cols_reg, MAXC);
      rows = size_limit(rows_reg, MAXR);
      burst = (cols * rows > 512) ? 40 : $urandom_range(130, 60);
      steady = (phase == 4 || phase == 5);
      for (int k = 0; k < burst && sent < ITEM_TOTAL; k++) begin
        pick = $urandom_range(99);
        code = 8'($urandom_range(255));
        tcol = 8'($urandom_range(1) ? $urandom_range(255) : $urandom_range(cols - 1));
        trow = 8'($urandom_range(1) ? $urandom_range(255) : $urandom_range(rows - 1));
        if (pick < 50) begin
          op = OP_PUT;
        end else if (pick < 60) begin
          op = OP_PUT;
          code = $urandom_range(1) ? LINE_FEED : CARRIAGE_RET;
        end else if (pick < 75) begin
          op = OP_MOVE;
        end else if (pick < 95) begin
          op = OP_READ;
        end else begin
          op = OP_CLEAR;
        end
        if ($urandom_range(99) == 0) settle();
        send_cmd(op, code, tcol, trow, 1'b0, '0);
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (12) @(posedge clk);
    if (faults == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
